// ----- design/rgbhsv_pkg.sv -----
// Shared types, constants and the hue window table for the RGB to HSV classifier.
// No dependencies; every other design file imports this package.
package rgbhsv_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned QUO_W      = 8;
    localparam int unsigned NUM_W      = 2 * CH_W;
    localparam int unsigned DSH_W      = CH_W + QUO_W - 1;
    localparam int unsigned DIV_STAGES = QUO_W;
    localparam int unsigned NUM_WIN    = 7;

    localparam logic [CH_W-1:0] HUE_SPAN     = 8'd43;
    localparam logic [CH_W-1:0] HUE_BASE_R   = 8'd0;
    localparam logic [CH_W-1:0] HUE_BASE_G   = 8'd85;
    localparam logic [CH_W-1:0] HUE_BASE_B   = 8'd171;
    localparam logic [CH_W-1:0] MIN_SAT_RST  = 8'd102;
    localparam logic [CH_W-1:0] MIN_VAL_RST  = 8'd102;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_RED    = 3'd1,
        CLS_GREEN  = 3'd2,
        CLS_BLUE   = 3'd3,
        CLS_LGREEN = 3'd4,
        CLS_LBLUE  = 3'd5,
        CLS_PURPLE = 3'd6,
        CLS_ROSE   = 3'd7
    } t_color_class;

    typedef enum logic {
        CFG_MIN_SAT = 1'b0,
        CFG_MIN_VAL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CH_W-1:0] lo;
        logic [CH_W-1:0] hi;
        t_color_class    cls;
    } t_window;

    // Priority order: first matching window wins.
    localparam t_window WINDOWS [NUM_WIN] = '{
        '{8'd242, 8'd249, CLS_RED},
        '{8'd70,  8'd89,  CLS_GREEN},
        '{8'd135, 8'd153, CLS_BLUE},
        '{8'd60,  8'd70,  CLS_LGREEN},
        '{8'd114, 8'd124, CLS_LBLUE},
        '{8'd160, 8'd175, CLS_PURPLE},
        '{8'd229, 8'd237, CLS_ROSE}
    };

    // Per-pixel data that rides alongside the dividers.
    typedef struct packed {
        logic [CH_W-1:0] base;
        logic            neg;
        logic            skip;
        logic [CH_W-1:0] vmax;
        logic            zero;
    } t_side;

    // One restoring-division lane: partial remainder, shifted divisor, quotient so far.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } t_div;

endpackage

// ----- design/rgbhsv_prep.sv -----
// Front end: max/min search, hue base and difference, then the divider operands.
// Depends on rgbhsv_pkg.
module rgbhsv_prep import rgbhsv_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output logic            o_valid,
    output t_side           o_side,
    output t_div            o_sat,
    output t_div            o_hue
);

    logic            r_valid1, n_valid1;
    logic [CH_W-1:0] r_vmax, n_vmax;
    logic [CH_W-1:0] r_d, n_d;
    logic [CH_W-1:0] r_mag, n_mag;
    logic [CH_W-1:0] r_base, n_base;
    logic            r_neg, n_neg;
    logic            r_skip, n_skip;

    logic            r_valid2;
    t_side           r_side, n_side;
    t_div            r_sat, n_sat;
    t_div            r_hue, n_hue;

    logic [CH_W-1:0] vmin;
    logic [CH_W:0]   diff;

    // stage 1: extremes and signed difference, kept as sign and magnitude
    always_comb begin
        n_vmax = i_red;
        if (i_green > n_vmax) n_vmax = i_green;
        if (i_blue > n_vmax)  n_vmax = i_blue;
        vmin = i_red;
        if (i_green < vmin) vmin = i_green;
        if (i_blue < vmin)  vmin = i_blue;
        n_d = n_vmax - vmin;

        if (n_vmax == i_red) begin
            n_base = HUE_BASE_R;
            diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (n_vmax == i_green) begin
            n_base = HUE_BASE_G;
            diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_base = HUE_BASE_B;
            diff   = {1'b0, i_red} - {1'b0, i_green};
        end
        n_neg  = diff[CH_W];
        n_mag  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
        n_skip = (i_red == '0) || (i_green == '0) || (i_blue == '0);
        n_valid1 = i_valid;
    end

    // stage 2: numerators and divisors pre-shifted to the top quotient bit
    always_comb begin
        n_side.base = r_base;
        n_side.neg  = r_neg;
        n_side.skip = r_skip;
        n_side.vmax = r_vmax;
        n_side.zero = (r_d == '0);

        n_sat.rem = {r_d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, r_d};
        n_sat.dsh = {r_vmax, {(QUO_W-1){1'b0}}};
        n_sat.quo = '0;

        n_hue.rem = {{CH_W{1'b0}}, r_mag} * {{CH_W{1'b0}}, HUE_SPAN};
        n_hue.dsh = {r_d, {(QUO_W-1){1'b0}}};
        n_hue.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= n_valid1;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vmax <= n_vmax;
        r_d    <= n_d;
        r_mag  <= n_mag;
        r_base <= n_base;
        r_neg  <= n_neg;
        r_skip <= n_skip;
        r_side <= n_side;
        r_sat  <= n_sat;
        r_hue  <= n_hue;
    end

    assign o_valid = r_valid2;
    assign o_side  = r_side;
    assign o_sat   = r_sat;
    assign o_hue   = r_hue;

endmodule

// ----- design/rgbhsv_div_step.sv -----
// One registered restoring-division step for both the saturation and hue lanes.
// Depends on rgbhsv_pkg.
module rgbhsv_div_step import rgbhsv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_div  i_sat,
    input  t_div  i_hue,
    output logic  o_valid,
    output t_side o_side,
    output t_div  o_sat,
    output t_div  o_hue
);

    logic  r_valid;
    t_side r_side;
    t_div  r_sat, n_sat;
    t_div  r_hue, n_hue;
    logic  sat_fit, hue_fit;

    // take one quotient bit, then halve the divisor for the next step
    always_comb begin
        sat_fit   = i_sat.rem >= {1'b0, i_sat.dsh};
        n_sat.rem = sat_fit ? i_sat.rem - {1'b0, i_sat.dsh} : i_sat.rem;
        n_sat.dsh = i_sat.dsh >> 1;
        n_sat.quo = {i_sat.quo[QUO_W-2:0], sat_fit};

        hue_fit   = i_hue.rem >= {1'b0, i_hue.dsh};
        n_hue.rem = hue_fit ? i_hue.rem - {1'b0, i_hue.dsh} : i_hue.rem;
        n_hue.dsh = i_hue.dsh >> 1;
        n_hue.quo = {i_hue.quo[QUO_W-2:0], hue_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_sat  <= n_sat;
        r_hue  <= n_hue;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_sat   = r_sat;
    assign o_hue   = r_hue;

endmodule

// ----- design/rgbhsv_classify.sv -----
// Back end: signed hue assembly, threshold checks and the priority window search.
// Depends on rgbhsv_pkg.
module rgbhsv_classify import rgbhsv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [QUO_W-1:0] i_sat_quo,
    input  logic [QUO_W-1:0] i_hue_quo,
    input  logic [CH_W-1:0]  i_min_sat,
    input  logic [CH_W-1:0]  i_min_val,
    output logic             o_valid,
    output logic [CH_W-1:0]  o_hue,
    output logic [CH_W-1:0]  o_saturation,
    output logic [CH_W-1:0]  o_brightness,
    output t_color_class     o_color_class,
    output logic             o_skipped
);

    logic            r_valid;
    logic [CH_W-1:0] r_hue, n_hue;
    logic [CH_W-1:0] r_sat, n_sat;
    logic [CH_W-1:0] r_val;
    t_color_class    r_cls, n_cls;
    logic            r_skip;
    logic [CH_W-1:0] offs;
    logic            found;

    always_comb begin
        offs  = i_side.neg ? CH_W'(-i_hue_quo) : CH_W'(i_hue_quo);
        n_hue = i_side.zero ? '0 : CH_W'(i_side.base + offs);
        n_sat = i_side.zero ? '0 : CH_W'(i_sat_quo);
        n_cls = CLS_NONE;
        found = 1'b0;
        if (!i_side.skip && n_sat >= i_min_sat && i_side.vmax >= i_min_val) begin
            for (int i = 0; i < NUM_WIN; i++) begin
                if (!found && n_hue >= WINDOWS[i].lo && n_hue <= WINDOWS[i].hi) begin
                    n_cls = WINDOWS[i].cls;
                    found = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue  <= n_hue;
        r_sat  <= n_sat;
        r_val  <= i_side.vmax;
        r_cls  <= n_cls;
        r_skip <= i_side.skip;
    end

    assign o_valid       = r_valid;
    assign o_hue         = r_hue;
    assign o_saturation  = r_sat;
    assign o_brightness  = r_val;
    assign o_color_class = r_cls;
    assign o_skipped     = r_skip;

    a_skip_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_skip |-> r_cls == CLS_NONE)
        else $error("skipped pixel carries a color class");

    a_grey_no_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_sat == '0 |-> r_hue == '0)
        else $error("zero saturation with nonzero hue");

    a_black_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_val == '0 |-> r_sat == '0 && r_skip)
        else $error("black pixel with saturation or not skipped");

    a_class_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && n_sat < i_min_sat |=> r_cls == CLS_NONE)
        else $error("class given below saturation minimum");

endmodule

// ----- design/rgb_to_hsv_color_classifier.sv -----
// A pixel taken on start shows its result with o_valid once it has passed the stages below.
// Throughput: one pixel every clock; busy stays low, the pipeline never stalls.
// Depth is set by the two restoring dividers, one quotient bit per register stage (8),
// plus two front stages (extremes, divider operands) and one classification stage.
// Reset (i_rst_n low, synchronous) drops all in-flight beats and loads both
// thresholds with 102; o_valid is low until a new beat reaches the output.
module rgb_to_hsv_color_classifier import rgbhsv_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [CH_W-1:0] i_cfg_data,
    output logic            o_valid,
    output logic [CH_W-1:0] o_hue,
    output logic [CH_W-1:0] o_saturation,
    output logic [CH_W-1:0] o_brightness,
    output logic [2:0]      o_color_class,
    output logic            o_skipped
);

    logic [CH_W-1:0] r_min_sat;
    logic [CH_W-1:0] r_min_val;

    // Divider chain taps: entry 0 comes from the front end, the last feeds the classifier.
    logic  valid_pipe [DIV_STAGES+1];
    t_side side_pipe  [DIV_STAGES+1];
    t_div  sat_pipe   [DIV_STAGES+1];
    t_div  hue_pipe   [DIV_STAGES+1];

    t_color_class cls;

    // Every beat is taken; nothing downstream can hold the pipeline.
    assign busy = 1'b0;

    // Threshold registers; the user must write them only while no beat is in flight, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sat <= MIN_SAT_RST;
            r_min_val <= MIN_VAL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_SAT: r_min_sat <= i_cfg_data;
                CFG_MIN_VAL: r_min_val <= i_cfg_data;
            endcase
        end
    end

    // Front end: max/min, hue base and difference, numerators and divisors.
    rgbhsv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (valid_pipe[0]),
        .o_side  (side_pipe[0]),
        .o_sat   (sat_pipe[0]),
        .o_hue   (hue_pipe[0])
    );

    // Advance both quotients one bit per stage, MSB first.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        rgbhsv_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_pipe[s]),
            .i_side  (side_pipe[s]),
            .i_sat   (sat_pipe[s]),
            .i_hue   (hue_pipe[s]),
            .o_valid (valid_pipe[s+1]),
            .o_side  (side_pipe[s+1]),
            .o_sat   (sat_pipe[s+1]),
            .o_hue   (hue_pipe[s+1])
        );
    end

    // Hue sign and wrap, thresholds, window priority search; registered outputs.
    rgbhsv_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (valid_pipe[DIV_STAGES]),
        .i_side        (side_pipe[DIV_STAGES]),
        .i_sat_quo     (sat_pipe[DIV_STAGES].quo),
        .i_hue_quo     (hue_pipe[DIV_STAGES].quo),
        .i_min_sat     (r_min_sat),
        .i_min_val     (r_min_val),
        .o_valid       (o_valid),
        .o_hue         (o_hue),
        .o_saturation  (o_saturation),
        .o_brightness  (o_brightness),
        .o_color_class (cls),
        .o_skipped     (o_skipped)
    );

    assign o_color_class = cls;

endmodule

// ----- verif/rgb_to_hsv_color_classifier_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_color_classifier: drives pixel beats, predicts HSV
// and color class per pixel, compares every result. Depends on rgbhsv_pkg and the DUT.
module rgb_to_hsv_color_classifier_tb;
    import rgbhsv_pkg::*;

    localparam int LATENCY     = 11;      // start to o_valid
    localparam int CYCLE_LIMIT = 200000;  // many times the slowest legal run

    typedef struct {
        logic [7:0]   hue;
        logic [7:0]   sat;
        logic [7:0]   val;
        t_color_class cls;
        logic         skip;
    } hsv_pixel_t;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    logic [7:0] i_red      = '0;
    logic [7:0] i_green    = '0;
    logic [7:0] i_blue     = '0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_hue;
    logic [7:0] o_saturation;
    logic [7:0] o_brightness;
    logic [2:0] o_color_class;
    logic       o_skipped;

    // Own copy of the two thresholds; mirrors the DUT reset value.
    logic [7:0] sat_floor = 8'd102;
    logic [7:0] val_floor = 8'd102;

    hsv_pixel_t expected_pixels[$];
    int         error_count = 0;
    int         cycle_count = 0;
    bit         gaps_on     = 1'b1;

    rgb_to_hsv_color_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_hue         (o_hue),
        .o_saturation  (o_saturation),
        .o_brightness  (o_brightness),
        .o_color_class (o_color_class),
        .o_skipped     (o_skipped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hue windows in priority order; the first hit wins, so hue 70 lands in green.
    function automatic t_color_class hue_window_class(input logic [7:0] h);
        if (h >= 8'd242 && h <= 8'd249) return CLS_RED;
        if (h >= 8'd70  && h <= 8'd89)  return CLS_GREEN;
        if (h >= 8'd135 && h <= 8'd153) return CLS_BLUE;
        if (h >= 8'd60  && h <= 8'd70)  return CLS_LGREEN;
        if (h >= 8'd114 && h <= 8'd124) return CLS_LBLUE;
        if (h >= 8'd160 && h <= 8'd175) return CLS_PURPLE;
        if (h >= 8'd229 && h <= 8'd237) return CLS_ROSE;
        return CLS_NONE;
    endfunction

    // Convert one pixel to HSV and pick its class against the current thresholds.
    function automatic hsv_pixel_t classify_pixel(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        int         rr, gg, bb, vmax, vmin, span, sat, base, diff, quot;
        hsv_pixel_t res;
        rr   = r;
        gg   = g;
        bb   = b;
        vmax = rr;
        if (gg > vmax) vmax = gg;
        if (bb > vmax) vmax = bb;
        vmin = rr;
        if (gg < vmin) vmin = gg;
        if (bb < vmin) vmin = bb;
        span = vmax - vmin;
        sat  = 0;
        res.hue = 8'd0;
        // Black keeps hue and saturation at zero; grey keeps hue at zero.
        if (vmax != 0) begin
            sat = (255 * span) / vmax;
            if (sat != 0 && span != 0) begin
                // Ties on the maximum favor red, then green.
                if (vmax == rr) begin
                    base = 0;
                    diff = gg - bb;
                end else if (vmax == gg) begin
                    base = 85;
                    diff = bb - rr;
                end else begin
                    base = 171;
                    diff = rr - gg;
                end
                quot    = (43 * diff) / span;   // truncates toward zero
                res.hue = 8'(base + quot);      // wrap modulo 256
            end
        end
        res.sat  = 8'(sat);
        res.val  = 8'(vmax);
        res.skip = (rr == 0 || gg == 0 || bb == 0);
        res.cls  = CLS_NONE;
        if (!res.skip && res.sat >= sat_floor && res.val >= val_floor)
            res.cls = hue_window_class(res.hue);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Check the beat leaving the DUT against the oldest prediction, then record the
    // beat entering it. Both use pre-edge values, so ordering within the step is moot.
    always @(posedge i_clk) begin : pixel_scoreboard
        hsv_pixel_t want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing pending, hue", o_hue, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_hue !== want.hue)           report_mismatch("hue", o_hue, want.hue);
                if (o_saturation !== want.sat)
                    report_mismatch("saturation", o_saturation, want.sat);
                if (o_brightness !== want.val)
                    report_mismatch("brightness", o_brightness, want.val);
                if (o_color_class !== want.cls)
                    report_mismatch("color_class", o_color_class, want.cls);
                if (o_skipped !== want.skip)      report_mismatch("skipped", o_skipped, want.skip);
            end
        end
        if (i_rst_n && start && !busy)
            expected_pixels = {expected_pixels, classify_pixel(i_red, i_green, i_blue)};
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one pixel beat and hold it until the DUT takes it; maybe idle afterwards.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        start   <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Drop start and hold off until every predicted result has come back.
    task automatic wait_drain();
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write both thresholds back to back; call only with the pipeline drained.
    task automatic set_thresholds(input logic [7:0] sat_min, input logic [7:0] val_min);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_SAT;
        i_cfg_data <= sat_min;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MIN_VAL;
        i_cfg_data <= val_min;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sat_floor = sat_min;
        val_floor = val_min;
    endtask

    // Random pixel, skewed toward the interesting regions: zero channels, near-grey, ties.
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                                output logic [7:0] b);
        int         sel;
        logic [2:0] zmask;
        logic [7:0] top, low;
        sel = $urandom_range(0, 99);
        r   = 8'($urandom_range(1, 255));
        g   = 8'($urandom_range(1, 255));
        b   = 8'($urandom_range(1, 255));
        if (sel < 15) begin
            zmask = 3'($urandom_range(1, 7));
            if (zmask[0]) r = 8'd0;
            if (zmask[1]) g = 8'd0;
            if (zmask[2]) b = 8'd0;
        end else if (sel < 27) begin
            top = 8'($urandom_range(0, 255));
            r   = top;
            g   = (top >= 3) ? top - 8'($urandom_range(0, 3)) : top;
            b   = (top >= 3) ? top - 8'($urandom_range(0, 3)) : top;
        end else if (sel < 37) begin
            top = 8'($urandom_range(1, 255));
            low = 8'($urandom_range(0, top));
            case ($urandom_range(0, 2))
                0: begin r = top; g = top; b = low; end
                1: begin r = low; g = top; b = top; end
                default: begin r = top; g = low; b = top; end
            endcase
        end
    endtask

    // Extremes and named special cases at the reset thresholds.
    task automatic test_special_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);    // black
        send_pixel(8'd255, 8'd255, 8'd255);  // white, grey
        send_pixel(8'd1,   8'd1,   8'd1);    // dim grey
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);    // pure primaries, all skipped
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd200, 8'd200, 8'd50);   // red and green tie on max
        send_pixel(8'd50,  8'd200, 8'd200);  // green and blue tie
        send_pixel(8'd200, 8'd50,  8'd200);  // red and blue tie
        send_pixel(8'd255, 8'd10,  8'd0);    // colored but one channel zero
        send_pixel(8'd135, 8'd200, 8'd100);  // hue 70, overlap of green and light green
        send_pixel(8'd200, 8'd50,  8'd89);   // red window after wrap
        send_pixel(8'd60,  8'd90,  8'd200);
        send_pixel(8'd120, 8'd200, 8'd60);
        send_pixel(8'd60,  8'd180, 8'd220);
        send_pixel(8'd180, 8'd60,  8'd220);
        send_pixel(8'd220, 8'd60,  8'd140);
        send_pixel(8'd255, 8'd254, 8'd1);
        send_pixel(8'd1,   8'd2,   8'd255);
        send_pixel(8'd101, 8'd10,  8'd20);   // just under brightness floor
        send_pixel(8'd102, 8'd10,  8'd20);   // exactly at the floor
        wait_drain();
    endtask

    // Both thresholds at their lowest and then at their highest.
    task automatic test_threshold_extremes();
        logic [7:0] r, g, b;
        set_thresholds(8'd0, 8'd0);
        send_pixel(8'd1, 8'd2, 8'd3);
        repeat (8) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        wait_drain();
        set_thresholds(8'd255, 8'd255);
        send_pixel(8'd255, 8'd1, 8'd1);
        repeat (8) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        wait_drain();
    endtask

    // Random pixels over several threshold settings, with a full drain mid-phase.
    task automatic test_random_pixels();
        logic [7:0] r, g, b;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0) set_thresholds(8'd102, 8'd102);
            else            set_thresholds(8'($urandom_range(40, 200)),
                                           8'($urandom_range(40, 200)));
            for (int n = 0; n < 100; n++) begin
                if (n == 50) wait_drain();
                random_pixel(r, g, b);
                send_pixel(r, g, b);
            end
            wait_drain();
        end
    endtask

    // Back-to-back beats with no idling at all.
    task automatic test_steady_stream();
        logic [7:0] r, g, b;
        gaps_on = 1'b0;
        set_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat (100) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        wait_drain();
    endtask

    initial begin
        // Hold reset, then release on a rising edge.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_pixels();
        test_threshold_extremes();
        test_random_pixels();
        test_steady_stream();

        // Let any stray beat surface before the verdict.
        repeat (2 * LATENCY) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- rgb_to_hsv_color_classifier.f -----
design/rgbhsv_pkg.sv
design/rgbhsv_prep.sv
design/rgbhsv_div_step.sv
design/rgbhsv_classify.sv
design/rgb_to_hsv_color_classifier.sv
verif/rgb_to_hsv_color_classifier_tb.sv
